// ===== src/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and character helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

    // fixed field widths of the request and result
    localparam int VALUE_IN_W  = 64;
    localparam int RADIX_W     = 2;
    localparam int WIDTH_IN_W  = 6;
    localparam int CNT_W       = 7;   // space_left width, also holds any char count
    localparam int CHAR_W      = 8;

    // s_tdata field offsets, lowest field first
    localparam int VALUE_LSB   = 0;
    localparam int RADIX_LSB   = VALUE_LSB + VALUE_IN_W;
    localparam int PAD_LSB     = RADIX_LSB + RADIX_W;
    localparam int WIDTH_LSB   = PAD_LSB + 1;
    localparam int SPACE_LSB   = WIDTH_LSB + WIDTH_IN_W;
    localparam int S_DATA_W    = SPACE_LSB + CNT_W;
    localparam int M_DATA_W    = CHAR_W;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_DEC    = 2'd0,
        RADIX_HEX_LO = 2'd1,
        RADIX_HEX_UP = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic hex;
    } conv_req_t;

    typedef struct packed {
        logic             load;
        logic             upper;
        logic             pad_zero;
        logic [CNT_W-1:0] npad;
        logic [CNT_W-1:0] count;
    } emit_req_t;

    // one digit nibble to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib,
                                                     input logic       upper);
        logic [CHAR_W-1:0] ext;
        begin
            ext = {4'd0, nib};
            if (nib < 4'd10)
                digit_char = CHAR_ZERO + ext;
            else if (upper)
                digit_char = CHAR_UPPER_A + ext - 8'd10;
            else
                digit_char = CHAR_LOWER_A + ext - 8'd10;
        end
    endfunction

endpackage

// ===== src/ita_conv.sv =====
// ----------------------------------------------------------------------------
// ita_conv
// Bit-serial binary to digit converter: one shift / add-3 step per cycle.
// Decimal uses the add-3 adjust, hex shifts plain nibbles.
// ----------------------------------------------------------------------------
module ita_conv #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ita_pkg::conv_req_t            req,
    input  logic [VALUE_BITS-1:0]         value,
    output logic                          busy,
    output logic [4*MAX_DIGITS-1:0]       digits,
    output logic [$clog2(MAX_DIGITS+1)-1:0] ndig
);

    localparam int DIG_W     = 4 * MAX_DIGITS;
    localparam int NDIG_W    = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W    = $clog2(MAX_DIGITS);
    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic [BIT_CNT_W-1:0]  bits_reg, bits_next;
    logic                  hex_reg, hex_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [DIG_W-1:0]      bcd_reg, bcd_next;
    logic [NDIG_W-1:0]     ndig_reg, ndig_next;

    logic [DIG_W-1:0]      adj;
    logic [DIG_W-1:0]      stepped;
    logic [DIDX_W-1:0]     top_idx;
    logic [3:0]            top_nib;

    // shared step unit: adjust every digit, then shift in the next value bit
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (!hex_reg && (bcd_reg[4*i +: 4] >= 4'd5))
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
        stepped = {adj[DIG_W-2:0], shift_reg[VALUE_BITS-1]};
        top_idx = ndig_reg[DIDX_W-1:0];
        top_nib = stepped[4*top_idx +: 4];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        bits_next  = bits_reg;
        hex_next   = hex_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        ndig_next  = ndig_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            bits_next  = BIT_CNT_W'(VALUE_BITS);
            hex_next   = req.hex;
            shift_next = value;
            bcd_next   = '0;
            ndig_next  = NDIG_W'(1);
        end
        else if (busy_reg)
        begin
            bits_next  = bits_reg - BIT_CNT_W'(1);
            shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next   = stepped;
            // a doubling adds at most one digit, so one look above the top is enough
            if ((ndig_reg < NDIG_W'(MAX_DIGITS)) && (top_nib != 4'd0))
                ndig_next = ndig_reg + NDIG_W'(1);
            if (bits_reg == BIT_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        bits_reg  <= bits_next;
        hex_reg   <= hex_next;
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        ndig_reg  <= ndig_next;
    end

    assign busy   = busy_reg;
    assign digits = bcd_reg;
    assign ndig   = ndig_reg;

endmodule

// ===== src/ita_emit.sv =====
// ----------------------------------------------------------------------------
// ita_emit
// Character sequencer: pad characters, then digits most significant first,
// one character per accepted result.
// ----------------------------------------------------------------------------
module ita_emit #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ita_pkg::emit_req_t              req,
    input  logic [$clog2(MAX_DIGITS+1)-1:0] ndig,
    input  logic [4*MAX_DIGITS-1:0]         digits,
    input  logic                            ready,
    output logic                            valid,
    output logic [ita_pkg::CHAR_W-1:0]      out_char,
    output logic                            is_last
);

    localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = ita_pkg::CNT_W;

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  pad_left_reg, pad_left_next;
    logic [DIDX_W-1:0] didx_reg, didx_next;
    logic              upper_reg, upper_next;
    logic              pad_zero_reg, pad_zero_next;
    logic [NDIG_W-1:0] ndig_m1;

    assign ndig_m1 = ndig - NDIG_W'(1);

    always_comb
    begin
        rem_next      = rem_reg;
        pad_left_next = pad_left_reg;
        didx_next     = didx_reg;
        upper_next    = upper_reg;
        pad_zero_next = pad_zero_reg;
        if (req.load)
        begin
            rem_next      = req.count;
            pad_left_next = req.npad;
            didx_next     = ndig_m1[DIDX_W-1:0];
            upper_next    = req.upper;
            pad_zero_next = req.pad_zero;
        end
        else if ((rem_reg != '0) && ready)
        begin
            rem_next = rem_reg - CNT_W'(1);
            if (pad_left_reg != '0)
                pad_left_next = pad_left_reg - CNT_W'(1);
            else
                didx_next = didx_reg - DIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        pad_left_reg <= pad_left_next;
        didx_reg     <= didx_next;
        upper_reg    <= upper_next;
        pad_zero_reg <= pad_zero_next;
    end

    always_comb
    begin
        if (pad_left_reg != '0)
            out_char = pad_zero_reg ? ita_pkg::CHAR_ZERO : ita_pkg::CHAR_SPACE;
        else
            out_char = ita_pkg::digit_char(digits[4*didx_reg +: 4], upper_reg);
    end

    assign valid   = (rem_reg != '0);
    assign is_last = (rem_reg == CNT_W'(1));

endmodule

// ===== src/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Renders an unsigned value as ASCII decimal or hex text with left padding,
// truncated to the free buffer space, one character per result.
// ----------------------------------------------------------------------------
// One request at a time. The idle state takes the request, then the shared
// shift/add-3 unit builds the digits (one value bit per cycle), the
// character sequencer is loaded once the converter is done, one
// character leaves per cycle while m_tready is high, and the unit then
// returns to idle.
// s_tready is high only in the idle state.
// Mode 3 renders as uppercase hex; values with more than MAX_DIGITS digits
// keep only their low-order digits.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS      = 64,
    parameter int MAX_FIELD_WIDTH = 40,
    parameter int MAX_DIGITS      = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value[63:0], radix_mode[65:64], pad_zero[66], min_width[72:67], space_left[79:73]
    input  logic [ita_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_char[7:0]
    output logic [ita_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);

    localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
    localparam int CNT_W  = ita_pkg::CNT_W;

    ita_pkg::state_t    state_reg, state_next;
    ita_pkg::radix_t    radix_reg;
    logic               pad_zero_reg;
    logic [ita_pkg::WIDTH_IN_W-1:0] width_reg;
    logic [CNT_W-1:0]   space_reg;

    ita_pkg::conv_req_t conv_req;
    ita_pkg::emit_req_t emit_req;
    logic               emit_load;
    logic               conv_busy;
    logic [4*MAX_DIGITS-1:0] digits;
    logic [NDIG_W-1:0]  ndig;
    logic               accept;
    ita_pkg::radix_t    radix_in;

    logic [CNT_W-1:0]   width_ext, width_sat, ndig_ext, npad, total;

    assign radix_in = ita_pkg::radix_t'(s_tdata[ita_pkg::RADIX_LSB +: ita_pkg::RADIX_W]);
    assign accept   = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ita_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ita_pkg::ST_CONV;
            end
            ita_pkg::ST_CONV:
            begin
                if (!conv_busy)
                    state_next = ita_pkg::ST_EMIT;
            end
            ita_pkg::ST_EMIT:
            begin
                if (!m_tvalid)
                    state_next = ita_pkg::ST_IDLE;
            end
            default:
                state_next = ita_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready  = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            ita_pkg::ST_IDLE:
                s_tready = 1'b1;
            ita_pkg::ST_CONV:
                emit_load = !conv_busy;
            ita_pkg::ST_EMIT:
                s_tready = 1'b0;
            default:
                s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ita_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            radix_reg    <= radix_in;
            pad_zero_reg <= s_tdata[ita_pkg::PAD_LSB];
            width_reg    <= s_tdata[ita_pkg::WIDTH_LSB +: ita_pkg::WIDTH_IN_W];
            space_reg    <= s_tdata[ita_pkg::SPACE_LSB +: CNT_W];
        end
    end

    assign conv_req.start = accept;
    assign conv_req.hex   = (radix_in != ita_pkg::RADIX_DEC);

    // field layout: pad count and emitted length
    always_comb
    begin
        width_ext = CNT_W'(width_reg);
        width_sat = (width_ext > CNT_W'(MAX_FIELD_WIDTH)) ? CNT_W'(MAX_FIELD_WIDTH) : width_ext;
        ndig_ext  = CNT_W'(ndig);
        npad      = (width_sat > ndig_ext) ? (width_sat - ndig_ext) : '0;
        total     = npad + ndig_ext;
    end

    assign emit_req.load     = emit_load;
    assign emit_req.upper    = (radix_reg != ita_pkg::RADIX_DEC) &&
                               (radix_reg != ita_pkg::RADIX_HEX_LO);
    assign emit_req.pad_zero = pad_zero_reg;
    assign emit_req.npad     = npad;
    assign emit_req.count    = (space_reg < total) ? space_reg : total;

    ita_conv #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (conv_req),
        .value  (s_tdata[ita_pkg::VALUE_LSB +: VALUE_BITS]),
        .busy   (conv_busy),
        .digits (digits),
        .ndig   (ndig)
    );

    ita_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (emit_req),
        .ndig     (ndig),
        .digits   (digits),
        .ready    (m_tready),
        .valid    (m_tvalid),
        .out_char (m_tdata),
        .is_last  (m_tlast)
    );

endmodule
